// ===== hdl/frc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared widths, status codes, configuration indexes and the request and result structs.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 16;

  // Offset carried by the identifier, size and checksum bytes.
  localparam logic [ByteW-1:0] ByteOffset = 8'd48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_ID   = 1'b0,
    CFG_EXPECTED_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_HEADER   = 3'd0,
    ST_STORED   = 3'd1,
    ST_GOOD     = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_BAD_SIZE = 3'd4,
    ST_BAD_CS   = 3'd5,
    ST_DROPPED  = 3'd6,
    ST_UNLOCKED = 3'd7
  } status_e;

  typedef struct packed {
    status_e          status;
    logic             write_valid;
    logic [SizeW-1:0] write_index;
    logic [ByteW-1:0] write_data;
    logic             frame_done;
  } res_t;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] rx_byte;
  } req_t;

endpackage

// ===== hdl/frc_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface frc_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [frc_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface frc_res_if;
  logic                        valid;
  logic                        ready;
  logic [frc_pkg::StatusW-1:0] status;
  logic                        write_valid;
  logic [frc_pkg::SizeW-1:0]   write_index;
  logic [frc_pkg::ByteW-1:0]   write_data;
  logic                        frame_done;

  modport source (output valid, output status, output write_valid, output write_index,
                  output write_data, output frame_done, input ready);
  modport sink   (input valid, input status, input write_valid, input write_index,
                  input write_data, input frame_done, output ready);
endinterface

interface frc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [frc_pkg::CfgIdxW-1:0] index;
  logic [frc_pkg::CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/frame_receiver_checksum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver with additive checksum, top level
// Checks byte-framed packets and reports one result per request.
// ----------------------------------------------------------------------------
// Each request is either a received byte or an unlock command, and each one
// produces exactly one result. A frame is an identifier byte, a size high
// byte, a size low byte, the payload bytes and a checksum byte; the header
// and checksum bytes carry an offset of 48 that is removed modulo 256. Each
// payload byte is reported as a buffer write and added to an 8-bit sum that
// the checksum must match. A good frame leaves the receiver locked, and
// further bytes are dropped until an unlock request arrives. The block
// accepts one request per clock cycle while the result register is not
// stalled: a request is registered, decided by one short pass of compare
// and add logic against the frame state, and the result is loaded into
// the result register once that register is free. A stalled result
// register holds the pipeline, and the input register keeps taking requests
// as long as the held one can move on. The configuration port (index 0
// expected_id, index 1 expected_size) is always ready and should be written
// only while no request is in flight.
// ----------------------------------------------------------------------------
module frame_receiver_checksum_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  frc_req_if.sink   req_i,
  frc_res_if.source res_o,
  frc_cfg_if.sink   cfg_i
);

  frc_pkg::req_t in_req;
  frc_pkg::req_t s1_req;
  frc_pkg::res_t core_res;
  frc_pkg::res_t out_res;
  logic          s1_valid;
  logic          out_free;
  logic          adv;

  // The held request is decided and its result loaded in the same cycle.
  assign adv = s1_valid && out_free;

  assign in_req.func    = req_i.func;
  assign in_req.rx_byte = req_i.rx_byte;

  assign cfg_i.ready = 1'b1;

  frc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_req_i   (in_req),
    .in_ready_o (req_i.ready),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .req_o      (s1_req)
  );

  frc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .adv_i      (adv),
    .req_i      (s1_req),
    .res_o      (core_res)
  );

  frc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (out_res)
  );

  assign res_o.status      = out_res.status;
  assign res_o.write_valid = out_res.write_valid;
  assign res_o.write_index = out_res.write_index;
  assign res_o.write_data  = out_res.write_data;
  assign res_o.frame_done  = out_res.frame_done;

endmodule

// ===== hdl/frc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver input stage
// Registers one request; takes a new one whenever the held one moves on.
// ----------------------------------------------------------------------------
module frc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  frc_pkg::req_t in_req_i,
  output logic          in_ready_o,
  input  logic          adv_i,
  output logic          valid_o,
  output frc_pkg::req_t req_o
);

  logic          valid_q;
  frc_pkg::req_t req_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_o    = valid_q;
  assign req_o      = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

endmodule

// ===== hdl/frc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver core
// Frame state, configuration registers and the per-byte decision logic.
// ----------------------------------------------------------------------------
module frc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [frc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [frc_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                        adv_i,
  input  frc_pkg::req_t               req_i,
  output frc_pkg::res_t               res_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ID   = 3'd1,
    PH_SZH  = 3'd2,
    PH_SZL  = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [frc_pkg::ByteW-1:0]  size_high_q, size_high_d;
  logic [frc_pkg::SizeW-1:0]  byte_index_q, byte_index_d;
  logic [frc_pkg::ByteW-1:0]  running_sum_q, running_sum_d;
  logic                       locked_q, locked_d;
  logic [frc_pkg::ByteW-1:0]  expected_id_q;
  logic [frc_pkg::SizeW-1:0]  expected_size_q;

  logic [frc_pkg::ByteW-1:0]  stripped;
  logic [frc_pkg::SizeW-1:0]  rx_size;
  phase_e                     ph;

  assign stripped = req_i.rx_byte - frc_pkg::ByteOffset;
  assign rx_size  = {size_high_q, stripped};

  always_comb begin
    phase_d       = phase_q;
    size_high_d   = size_high_q;
    byte_index_d  = byte_index_q;
    running_sum_d = running_sum_q;
    locked_d      = locked_q;
    ph            = phase_q;
    res_o         = '0;
    res_o.status  = frc_pkg::ST_DROPPED;

    if (req_i.func) begin
      locked_d     = 1'b0;
      res_o.status = frc_pkg::ST_UNLOCKED;
    end else begin
      // An unlocked idle receiver treats the byte as the start of a frame.
      if (ph == PH_IDLE && !locked_q) begin
        locked_d      = 1'b1;
        byte_index_d  = '0;
        running_sum_d = '0;
        ph            = PH_ID;
      end
      case (ph)
        PH_IDLE: begin
          res_o.status = frc_pkg::ST_DROPPED;
        end
        PH_ID: begin
          if (stripped == expected_id_q) begin
            byte_index_d  = '0;
            running_sum_d = '0;
            ph            = PH_SZH;
            res_o.status  = frc_pkg::ST_HEADER;
          end else begin
            res_o.status = frc_pkg::ST_BAD_ID;
          end
        end
        PH_SZH: begin
          size_high_d  = stripped;
          ph           = PH_SZL;
          res_o.status = frc_pkg::ST_HEADER;
        end
        PH_SZL: begin
          if (rx_size == expected_size_q) begin
            ph           = PH_PAY;
            res_o.status = frc_pkg::ST_HEADER;
          end else begin
            res_o.status = frc_pkg::ST_BAD_SIZE;
          end
        end
        PH_PAY: begin
          if (byte_index_q < expected_size_q) begin
            res_o.write_valid = 1'b1;
            res_o.write_index = byte_index_q;
            res_o.write_data  = req_i.rx_byte;
            running_sum_d     = running_sum_q + req_i.rx_byte;
            byte_index_d      = byte_index_q + 16'd1;
            res_o.status      = frc_pkg::ST_STORED;
          end else if (stripped == running_sum_q) begin
            res_o.frame_done = 1'b1;
            ph               = PH_IDLE;
            res_o.status     = frc_pkg::ST_GOOD;
          end else begin
            res_o.status = frc_pkg::ST_BAD_CS;
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
      phase_d = ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      size_high_q     <= '0;
      byte_index_q    <= '0;
      running_sum_q   <= '0;
      locked_q        <= 1'b0;
      expected_id_q   <= '0;
      expected_size_q <= '0;
    end else begin
      if (adv_i) begin
        phase_q       <= phase_d;
        size_high_q   <= size_high_d;
        byte_index_q  <= byte_index_d;
        running_sum_q <= running_sum_d;
        locked_q      <= locked_d;
      end
      if (cfg_we_i) begin
        case (frc_pkg::cfg_idx_e'(cfg_idx_i))
          frc_pkg::CFG_EXPECTED_ID:   expected_id_q   <= cfg_data_i[frc_pkg::ByteW-1:0];
          frc_pkg::CFG_EXPECTED_SIZE: expected_size_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_is_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.frame_done |-> res_o.status == frc_pkg::ST_GOOD)
    else $error("frame_done without good status");

  a_good_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.frame_done |=> phase_q == PH_IDLE && locked_q == $past(locked_q))
    else $error("good frame did not return to idle with the lock unchanged");

  a_locked_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !req_i.func && phase_q == PH_IDLE && locked_q |=>
      phase_q == PH_IDLE && locked_q)
    else $error("locked idle receiver left idle on a byte");

  a_write_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.write_valid |-> phase_q == PH_PAY && byte_index_q < expected_size_q)
    else $error("buffer write outside the payload");
`endif

endmodule

// ===== hdl/frc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver output stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module frc_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  frc_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output frc_pkg::res_t res_o
);

  logic          valid_q;
  frc_pkg::res_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
